>>> rtl/cot_pkg.sv
// Shared types and fixed widths for the capsule overlap test.
`timescale 1ns / 1ps
package cot_pkg;

    localparam int POINT_W  = 48;
    localparam int RADIUS_W = 16;
    localparam int RSUM_W   = RADIUS_W + 1;
    localparam int RSQ_W    = 2 * RSUM_W;
    localparam int AXES     = 3;

    typedef struct packed {
        logic both_en;
        logic radii_zero;
        logic bottoms_eq;
    } t_flags;

    localparam int FLAGS_W = $bits(t_flags);

endpackage

>>> rtl/cot_mul.sv
// Two-stage signed multiplier, split into two partial products.
`timescale 1ns / 1ps
module cot_mul #(
    parameter int A_W = 36,
    parameter int B_W = 36
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [A_W-1:0]    i_a,
    input  logic signed [B_W-1:0]    i_b,
    output logic signed [A_W+B_W-1:0] o_p
);
    localparam int LO_W = B_W / 2;
    localparam int HI_W = B_W - LO_W;
    localparam int P_W  = A_W + B_W;

    logic signed [A_W+LO_W:0]   r_lo;
    logic signed [A_W+HI_W-1:0] r_hi;
    logic signed [P_W-1:0]      r_p;

    // low half is unsigned, high half carries the sign
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo <= (A_W+LO_W+1)'(i_a) * (A_W+LO_W+1)'($signed({1'b0, i_b[LO_W-1:0]}));
            r_hi <= (A_W+HI_W)'(i_a) * (A_W+HI_W)'($signed(i_b[B_W-1:LO_W]));
            r_p  <= (P_W'(r_hi) <<< LO_W) + P_W'(r_lo);
        end
    end

    assign o_p = r_p;

endmodule

>>> rtl/cot_div.sv
// Pipelined two-lane restoring divider giving clamped, floored fractions.
`timescale 1ns / 1ps
module cot_div #(
    parameter int P      = 16,
    parameter int NW     = 73,
    parameter int SIDE_W = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [NW-1:0] i_ns,
    input  logic [NW-1:0]        i_ds,
    input  logic signed [NW-1:0] i_nt,
    input  logic [NW-1:0]        i_dt,
    input  logic [SIDE_W-1:0]    i_side,
    output logic                 o_valid,
    output logic [P:0]           o_s,
    output logic [P:0]           o_t,
    output logic [SIDE_W-1:0]    o_side
);
    localparam int QW = P + 1;
    localparam int DW = NW;

    logic [P:0]        r_v;
    logic [DW-1:0]     r_rem  [0:P][2];
    logic [DW-1:0]     r_den  [0:P][2];
    logic [QW-1:0]     r_q    [0:P][2];
    logic              r_busy [0:P][2];
    logic [SIDE_W-1:0] r_side [0:P];

    logic signed [NW-1:0] w_n [2];
    logic [DW-1:0]        w_d [2];
    logic [DW-1:0]        w_sh [1:P][2];
    logic                 w_ge [1:P][2];

    assign w_n[0] = i_ns;
    assign w_n[1] = i_nt;
    assign w_d[0] = i_ds;
    assign w_d[1] = i_dt;

    always_comb begin
        for (int k = 1; k <= P; k++) begin
            for (int l = 0; l < 2; l++) begin
                w_sh[k][l] = {r_rem[k-1][l][DW-2:0], 1'b0};
                w_ge[k][l] = (w_sh[k][l] >= r_den[k-1][l]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[P-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // classify: non-positive gives zero, at or above the divisor gives one
            for (int l = 0; l < 2; l++) begin
                r_den[0][l] <= w_d[l];
                r_rem[0][l] <= DW'(w_n[l]);
                if (w_n[l][NW-1] || (w_n[l] == '0)) begin
                    r_q[0][l]    <= '0;
                    r_busy[0][l] <= 1'b0;
                end else if (DW'(w_n[l]) >= w_d[l]) begin
                    r_q[0][l]    <= {1'b1, {P{1'b0}}};
                    r_busy[0][l] <= 1'b0;
                end else begin
                    r_q[0][l]    <= '0;
                    r_busy[0][l] <= 1'b1;
                end
            end
            r_side[0] <= i_side;
            // one quotient bit per stage
            for (int k = 1; k <= P; k++) begin
                r_side[k] <= r_side[k-1];
                for (int l = 0; l < 2; l++) begin
                    r_den[k][l]  <= r_den[k-1][l];
                    r_busy[k][l] <= r_busy[k-1][l];
                    if (r_busy[k-1][l]) begin
                        r_q[k][l]   <= {r_q[k-1][l][QW-2:0], w_ge[k][l]};
                        r_rem[k][l] <= w_ge[k][l] ? (w_sh[k][l] - r_den[k-1][l]) : w_sh[k][l];
                    end else begin
                        r_q[k][l]   <= r_q[k-1][l];
                        r_rem[k][l] <= r_rem[k-1][l];
                    end
                end
            end
        end
    end

    assign o_valid = r_v[P];
    assign o_s     = r_q[P][0];
    assign o_t     = r_q[P][1];
    assign o_side  = r_side[P];

    a_q_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[P] |-> (r_q[P][0] <= {1'b1, {P{1'b0}}}) && (r_q[P][1] <= {1'b1, {P{1'b0}}}))
        else $error("quotient above one");

    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[P] && r_busy[P][0] |-> r_rem[P][0] < r_den[P][0])
        else $error("remainder not below divisor");

endmodule

>>> rtl/capsule_overlap_test_core.sv
// Top level of the capsule pair overlap test pipeline.
`timescale 1ns / 1ps
// Throughput: one item per cycle while the output is not stalled; the divider spends one stage per fraction bit.
// Every stage advances together; a held result at the output freezes the whole pipe.
// Reset (i_rst_n low, synchronous) clears all valid bits; data registers are not reset.
// No state is kept between items, so no clearing pass follows reset.
module capsule_overlap_test_core
    import cot_pkg::*;
#(
    parameter int COORD_BITS      = 16,
    parameter int PARAM_FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [POINT_W-1:0]  i_first_bottom,
    input  logic [POINT_W-1:0]  i_first_top,
    input  logic [POINT_W-1:0]  i_second_bottom,
    input  logic [POINT_W-1:0]  i_second_top,
    input  logic [RADIUS_W-1:0] i_first_radius,
    input  logic [RADIUS_W-1:0] i_second_radius,
    input  logic                i_first_enabled,
    input  logic                i_second_enabled,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_overlap
);
    localparam int C      = COORD_BITS;
    localparam int P      = PARAM_FRAC_BITS;
    localparam int PKW    = (AXES * C > POINT_W) ? AXES * C : POINT_W;
    localparam int DW1    = C + 1;            // axis and offset components
    localparam int PRW    = 2 * DW1;          // component products
    localparam int SW     = PRW + 2;          // dot products a, b, c, e, f
    localparam int PW2    = 2 * SW;           // products of dot products
    localparam int NW     = PW2 + 1;          // numerators and determinant
    localparam int QW     = P + 1;            // clamped parameters s, t
    localparam int DKW    = C + P + 4;        // scaled closest-point difference
    localparam int SQW    = 2 * DKW;
    localparam int LW     = SQW + 2;
    localparam int RHW    = RSQ_W + 2 * P;
    localparam int CMPW   = (LW > RHW) ? LW : RHW;
    localparam int GW     = 3 * AXES * DW1;   // packed d1, d2, r
    localparam int SIDE_W = GW + RSQ_W + FLAGS_W;

    // advance the whole pipe unless the output holds an item that is stalled
    logic w_adv;
    logic [5:0] r_sv;   // valid bits of the front stages
    logic [5:0] r_fv;   // valid bits of the back stages, top bit is the output

    assign w_adv   = !r_fv[5] || !i_stall;
    assign o_stall = !w_adv;
    assign o_valid = r_fv[5];

    // ---------------------------------------------------------------
    // Stage 1: sum radii, set enable and zero-radius flags, unpack coordinates, form axes d1, d2 and offset r
    // ---------------------------------------------------------------
    logic [PKW-1:0] w_fb, w_ft, w_sb, w_st;
    logic signed [DW1-1:0] n1_d1 [AXES];
    logic signed [DW1-1:0] n1_d2 [AXES];
    logic signed [DW1-1:0] n1_r  [AXES];

    assign w_fb = PKW'(i_first_bottom);
    assign w_ft = PKW'(i_first_top);
    assign w_sb = PKW'(i_second_bottom);
    assign w_st = PKW'(i_second_top);

    always_comb begin
        for (int k = 0; k < AXES; k++) begin
            n1_d1[k] = DW1'($signed(w_ft[k*C +: C])) - DW1'($signed(w_fb[k*C +: C]));
            n1_d2[k] = DW1'($signed(w_st[k*C +: C])) - DW1'($signed(w_sb[k*C +: C]));
            n1_r[k]  = DW1'($signed(w_fb[k*C +: C])) - DW1'($signed(w_sb[k*C +: C]));
        end
    end

    logic [GW-1:0]     r1_g;
    logic [RSUM_W-1:0] r1_rsum;
    t_flags            r1_fl;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < AXES; k++) begin
                r1_g[k*DW1 +: DW1]          <= n1_d1[k];
                r1_g[(AXES+k)*DW1 +: DW1]   <= n1_d2[k];
                r1_g[(2*AXES+k)*DW1 +: DW1] <= n1_r[k];
            end
            r1_rsum          <= RSUM_W'(i_first_radius) + RSUM_W'(i_second_radius);
            r1_fl.both_en    <= i_first_enabled & i_second_enabled;
            r1_fl.radii_zero <= (i_first_radius == '0) && (i_second_radius == '0);
            r1_fl.bottoms_eq <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: radius sum squared, bottoms-equal flag, component products for the five dot products
    // ---------------------------------------------------------------
    logic signed [DW1-1:0] w1_d1 [AXES];
    logic signed [DW1-1:0] w1_d2 [AXES];
    logic signed [DW1-1:0] w1_r  [AXES];

    always_comb begin
        for (int k = 0; k < AXES; k++) begin
            w1_d1[k] = $signed(r1_g[k*DW1 +: DW1]);
            w1_d2[k] = $signed(r1_g[(AXES+k)*DW1 +: DW1]);
            w1_r[k]  = $signed(r1_g[(2*AXES+k)*DW1 +: DW1]);
        end
    end

    logic signed [PRW-1:0] r2_pa [AXES];
    logic signed [PRW-1:0] r2_pe [AXES];
    logic signed [PRW-1:0] r2_pb [AXES];
    logic signed [PRW-1:0] r2_pc [AXES];
    logic signed [PRW-1:0] r2_pf [AXES];
    logic [GW-1:0]         r2_g;
    logic [RSQ_W-1:0]      r2_rsq;
    t_flags                r2_fl;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < AXES; k++) begin
                r2_pa[k] <= PRW'(w1_d1[k]) * PRW'(w1_d1[k]);
                r2_pe[k] <= PRW'(w1_d2[k]) * PRW'(w1_d2[k]);
                r2_pb[k] <= PRW'(w1_d1[k]) * PRW'(w1_d2[k]);
                r2_pc[k] <= PRW'(w1_d1[k]) * PRW'(w1_r[k]);
                r2_pf[k] <= PRW'(w1_d2[k]) * PRW'(w1_r[k]);
            end
            r2_g             <= r1_g;
            r2_rsq           <= RSQ_W'(r1_rsum) * RSQ_W'(r1_rsum);
            r2_fl.both_en    <= r1_fl.both_en;
            r2_fl.radii_zero <= r1_fl.radii_zero;
            r2_fl.bottoms_eq <= (r1_g[GW-1:2*AXES*DW1] == '0);
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: dot products a, e, b, c, f
    // ---------------------------------------------------------------
    logic signed [SW-1:0] r3_a, r3_e, r3_b, r3_c, r3_f;
    logic [GW-1:0]        r3_g;
    logic [RSQ_W-1:0]     r3_rsq;
    t_flags               r3_fl;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_a   <= SW'(r2_pa[0]) + SW'(r2_pa[1]) + SW'(r2_pa[2]);
            r3_e   <= SW'(r2_pe[0]) + SW'(r2_pe[1]) + SW'(r2_pe[2]);
            r3_b   <= SW'(r2_pb[0]) + SW'(r2_pb[1]) + SW'(r2_pb[2]);
            r3_c   <= SW'(r2_pc[0]) + SW'(r2_pc[1]) + SW'(r2_pc[2]);
            r3_f   <= SW'(r2_pf[0]) + SW'(r2_pf[1]) + SW'(r2_pf[2]);
            r3_g   <= r2_g;
            r3_rsq <= r2_rsq;
            r3_fl  <= r2_fl;
        end
    end

    // ---------------------------------------------------------------
    // Stages 4-5: determinant and numerator products (two-stage multipliers)
    // ---------------------------------------------------------------
    logic signed [PW2-1:0] m_ae, m_bb, m_bf, m_ec, m_af, m_bc;

    cot_mul #(.A_W(SW), .B_W(SW)) u_mul_ae (
        .i_clk(i_clk), .i_en(w_adv), .i_a(r3_a), .i_b(r3_e), .o_p(m_ae));
    cot_mul #(.A_W(SW), .B_W(SW)) u_mul_bb (
        .i_clk(i_clk), .i_en(w_adv), .i_a(r3_b), .i_b(r3_b), .o_p(m_bb));
    cot_mul #(.A_W(SW), .B_W(SW)) u_mul_bf (
        .i_clk(i_clk), .i_en(w_adv), .i_a(r3_b), .i_b(r3_f), .o_p(m_bf));
    cot_mul #(.A_W(SW), .B_W(SW)) u_mul_ec (
        .i_clk(i_clk), .i_en(w_adv), .i_a(r3_e), .i_b(r3_c), .o_p(m_ec));
    cot_mul #(.A_W(SW), .B_W(SW)) u_mul_af (
        .i_clk(i_clk), .i_en(w_adv), .i_a(r3_a), .i_b(r3_f), .o_p(m_af));
    cot_mul #(.A_W(SW), .B_W(SW)) u_mul_bc (
        .i_clk(i_clk), .i_en(w_adv), .i_a(r3_b), .i_b(r3_c), .o_p(m_bc));

    // carry the rest alongside the multipliers
    logic signed [SW-1:0] r4_a, r4_e, r4_c, r4_f, r5_a, r5_e, r5_c, r5_f;
    logic [GW-1:0]        r4_g, r5_g;
    logic [RSQ_W-1:0]     r4_rsq, r5_rsq;
    t_flags               r4_fl, r5_fl;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_a   <= r3_a;
            r4_e   <= r3_e;
            r4_c   <= r3_c;
            r4_f   <= r3_f;
            r4_g   <= r3_g;
            r4_rsq <= r3_rsq;
            r4_fl  <= r3_fl;
            r5_a   <= r4_a;
            r5_e   <= r4_e;
            r5_c   <= r4_c;
            r5_f   <= r4_f;
            r5_g   <= r4_g;
            r5_rsq <= r4_rsq;
            r5_fl  <= r4_fl;
        end
    end

    // ---------------------------------------------------------------
    // Stage 6: pick numerators and divisors for s and t
    // ---------------------------------------------------------------
    logic signed [NW-1:0] w_det, w_ns, w_nt;
    logic signed [NW-1:0] n6_ns, n6_nt;
    logic [NW-1:0]        n6_ds, n6_dt;

    assign w_det = NW'(m_ae) - NW'(m_bb);
    assign w_ns  = NW'(m_bf) - NW'(m_ec);
    assign w_nt  = NW'(m_af) - NW'(m_bc);

    always_comb begin
        if ((r5_a == '0) && (r5_e == '0)) begin
            // both axes degenerate: compare the bottoms
            n6_ns = '0;
            n6_ds = NW'(1);
            n6_nt = '0;
            n6_dt = NW'(1);
        end else if (w_det != '0) begin
            n6_ns = w_ns;
            n6_ds = NW'(w_det);
            n6_nt = w_nt;
            n6_dt = NW'(w_det);
        end else if (r5_e == '0) begin
            // only the second axis degenerate: s = -c/a
            n6_ns = -NW'(r5_c);
            n6_ds = NW'(r5_a);
            n6_nt = '0;
            n6_dt = NW'(1);
        end else begin
            // parallel axes or only the first axis degenerate: s = 0, t = f/e
            n6_ns = '0;
            n6_ds = NW'(1);
            n6_nt = NW'(r5_f);
            n6_dt = NW'(r5_e);
        end
    end

    logic signed [NW-1:0] r6_ns, r6_nt;
    logic [NW-1:0]        r6_ds, r6_dt;
    logic [GW-1:0]        r6_g;
    logic [RSQ_W-1:0]     r6_rsq;
    t_flags               r6_fl;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r6_ns  <= n6_ns;
            r6_ds  <= n6_ds;
            r6_nt  <= n6_nt;
            r6_dt  <= n6_dt;
            r6_g   <= r5_g;
            r6_rsq <= r5_rsq;
            r6_fl  <= r5_fl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= '0;
        end else if (w_adv) begin
            r_sv <= {r_sv[4:0], i_valid};
        end
    end

    // ---------------------------------------------------------------
    // Divider: clamp and quantise s and t, one fraction bit per stage
    // ---------------------------------------------------------------
    logic              dv_v;
    logic [QW-1:0]     dv_s, dv_t;
    logic [SIDE_W-1:0] dv_side;

    cot_div #(.P(P), .NW(NW), .SIDE_W(SIDE_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_sv[5]),
        .i_ns    (r6_ns),
        .i_ds    (r6_ds),
        .i_nt    (r6_nt),
        .i_dt    (r6_dt),
        .i_side  ({r6_g, r6_rsq, r6_fl}),
        .o_valid (dv_v),
        .o_s     (dv_s),
        .o_t     (dv_t),
        .o_side  (dv_side)
    );

    logic [GW-1:0]    w7_g;
    logic [RSQ_W-1:0] w7_rsq;
    t_flags           w7_fl;

    assign {w7_g, w7_rsq, w7_fl} = dv_side;

    // ---------------------------------------------------------------
    // Back stage 1: scaled terms r*2^P, d1*s, d2*t
    // ---------------------------------------------------------------
    logic signed [DKW-1:0] r7_pr [AXES];
    logic signed [DKW-1:0] r7_ps [AXES];
    logic signed [DKW-1:0] r7_pt [AXES];
    logic [RSQ_W-1:0]      r7_rsq;
    t_flags                r7_fl;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < AXES; k++) begin
                r7_pr[k] <= DKW'($signed(w7_g[(2*AXES+k)*DW1 +: DW1])) <<< P;
                r7_ps[k] <= DKW'($signed(w7_g[k*DW1 +: DW1])) * DKW'($signed({1'b0, dv_s}));
                r7_pt[k] <= DKW'($signed(w7_g[(AXES+k)*DW1 +: DW1]))
                            * DKW'($signed({1'b0, dv_t}));
            end
            r7_rsq <= w7_rsq;
            r7_fl  <= w7_fl;
        end
    end

    // Back stage 2: difference between the closest points, per axis
    logic signed [DKW-1:0] r8_dk [AXES];
    logic [RSQ_W-1:0]      r8_rsq, r9_rsq, r10_rsq;
    t_flags                r8_fl, r9_fl, r10_fl;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < AXES; k++) begin
                r8_dk[k] <= r7_pr[k] + r7_ps[k] - r7_pt[k];
            end
            r8_rsq  <= r7_rsq;
            r8_fl   <= r7_fl;
            r9_rsq  <= r8_rsq;
            r9_fl   <= r8_fl;
            r10_rsq <= r9_rsq;
            r10_fl  <= r9_fl;
        end
    end

    // Back stages 3-4: squares
    logic signed [SQW-1:0] m_sq [AXES];

    for (genvar g = 0; g < AXES; g++) begin : g_sq
        cot_mul #(.A_W(DKW), .B_W(DKW)) u_mul_sq (
            .i_clk(i_clk), .i_en(w_adv), .i_a(r8_dk[g]), .i_b(r8_dk[g]), .o_p(m_sq[g]));
    end

    // Back stage 5: squared distance
    logic [LW-1:0]    r11_lhs;
    logic [RSQ_W-1:0] r11_rsq;
    t_flags           r11_fl;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r11_lhs <= LW'(unsigned'(m_sq[0])) + LW'(unsigned'(m_sq[1]))
                       + LW'(unsigned'(m_sq[2]));
            r11_rsq <= r10_rsq;
            r11_fl  <= r10_fl;
        end
    end

    // Back stage 6: compare with the squared radius sum (bottoms if both radii are zero), hold the result
    logic [CMPW-1:0] w_rhs;
    logic            r_out;

    assign w_rhs = CMPW'(r11_rsq) << (2 * P);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= r11_fl.both_en
                     & (r11_fl.radii_zero ? r11_fl.bottoms_eq : (CMPW'(r11_lhs) <= w_rhs));
        end
    end

    assign o_overlap = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
        end else if (w_adv) begin
            r_fv <= {r_fv[4:0], dv_v};
        end
    end

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r_sv) && $stable(r_fv))
        else $error("pipeline moved while stalled");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_sv[0])
        else $error("accepted item lost at entry");

    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv[5] |-> (r6_ds != '0) && (r6_dt != '0))
        else $error("zero divisor sent to divider");

endmodule

>>> dv/capsule_overlap_test_core_test.sv
// Self-checking testbench for the capsule pair overlap test core.
`timescale 1ns / 1ps
module capsule_overlap_test_core_test;
    import cot_pkg::*;

    localparam int CB  = 16;
    localparam int PFB = 16;
    localparam int LATENCY = PFB + 13;

    typedef struct {
        logic [POINT_W-1:0]  fb, ft, sb, st;
        logic [RADIUS_W-1:0] fr, sr;
        logic                fe, se;
    } t_pair;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [POINT_W-1:0]  i_first_bottom = '0, i_first_top = '0;
    logic [POINT_W-1:0]  i_second_bottom = '0, i_second_top = '0;
    logic [RADIUS_W-1:0] i_first_radius = '0, i_second_radius = '0;
    logic                i_first_enabled = 1'b0, i_second_enabled = 1'b0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic                o_overlap;

    capsule_overlap_test_core #(.COORD_BITS(CB), .PARAM_FRAC_BITS(PFB)) dut (.*);

    always #5 i_clk = ~i_clk;

    t_pair pending_pairs[$];
    logic  expected_overlaps[$];
    int    n_errors = 0;
    int    n_hits = 0;
    int    n_results = 0;
    bit    calm = 1'b0;       // final stretch: no idling on either side
    bit    hold_off = 1'b0;   // sender waits for the pipe to drain

    // Sign-extend one packed coordinate.
    function automatic longint axis_coord(logic [POINT_W-1:0] p, int k);
        logic signed [CB-1:0] v;
        v = p[k*CB +: CB];
        return longint'(v);
    endfunction

    // Clamped, floored n/d with PFB fraction bits.
    function automatic longint clamp_ratio(logic signed [159:0] n, logic signed [159:0] d);
        if (n <= 0) return 0;
        if (n >= d) return longint'(1) << PFB;
        return longint'((n <<< PFB) / d);
    endfunction

    function automatic logic predict_overlap(t_pair x);
        longint d1[3], d2[3], r[3];
        longint a, e, b, c, f, s, t;
        logic signed [159:0] det, dk, dist_sq, reach_sq;
        longint rsum;
        a = 0; e = 0; b = 0; c = 0; f = 0;
        if (!x.fe || !x.se) return 1'b0;
        for (int k = 0; k < 3; k++) begin
            d1[k] = axis_coord(x.ft, k) - axis_coord(x.fb, k);
            d2[k] = axis_coord(x.st, k) - axis_coord(x.sb, k);
            r[k]  = axis_coord(x.fb, k) - axis_coord(x.sb, k);
        end
        if (x.fr == 0 && x.sr == 0) return (r[0] == 0 && r[1] == 0 && r[2] == 0);
        for (int k = 0; k < 3; k++) begin
            a += d1[k]*d1[k]; e += d2[k]*d2[k]; b += d1[k]*d2[k];
            c += d1[k]*r[k];  f += d2[k]*r[k];
        end
        if (a == 0 && e == 0) begin
            s = 0; t = 0;
        end else begin
            det = 160'(a)*160'(e) - 160'(b)*160'(b);
            if (det != 0) begin
                s = clamp_ratio(160'(b)*160'(f) - 160'(e)*160'(c), det);
                t = clamp_ratio(160'(a)*160'(f) - 160'(b)*160'(c), det);
            end else if (e == 0) begin
                s = clamp_ratio(-160'(c), 160'(a)); t = 0;
            end else begin
                s = 0; t = clamp_ratio(160'(f), 160'(e));
            end
        end
        dist_sq = 0;
        for (int k = 0; k < 3; k++) begin
            dk = (160'(r[k]) <<< PFB) + 160'(d1[k])*160'(s) - 160'(d2[k])*160'(t);
            dist_sq += dk*dk;
        end
        rsum = longint'(x.fr) + longint'(x.sr);
        reach_sq = (160'(rsum)*160'(rsum)) <<< (2*PFB);
        return reach_sq >= dist_sq;
    endfunction

    function automatic logic [POINT_W-1:0] rand_point(int spread);
        logic [POINT_W-1:0] p;
        for (int k = 0; k < 3; k++)
            p[k*CB +: CB] = (spread == 0) ? CB'($urandom)
                                          : CB'($urandom_range(0, 2*spread) - spread);
        return p;
    endfunction

    // Driver: present the next item; hold it while stalled.
    int send_gap = 0;
    always @(posedge i_clk) begin
        t_pair x;
        if (i_rst_n) begin
            if (!i_valid || !o_stall) begin
                if (send_gap > 0 && !calm) begin
                    send_gap <= send_gap - 1;
                    i_valid  <= 1'b0;
                end else if (!calm && $urandom_range(0, 9) == 0) begin
                    send_gap <= $urandom_range(1, 13) - 1;
                    i_valid  <= 1'b0;
                end else if (pending_pairs.size() > 0 && !hold_off) begin
                    x = pending_pairs.pop_front();
                    expected_overlaps.push_back(predict_overlap(x));
                    i_first_bottom   <= x.fb; i_first_top  <= x.ft;
                    i_second_bottom  <= x.sb; i_second_top <= x.st;
                    i_first_radius   <= x.fr; i_second_radius <= x.sr;
                    i_first_enabled  <= x.fe; i_second_enabled <= x.se;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall bursts.
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (calm) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(1, 13) - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Monitor: check every accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        logic want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_overlaps.size() == 0) begin
                $error("unexpected result overlap=%0b", o_overlap);
                n_errors++;
            end else begin
                want = expected_overlaps.pop_front();
                n_results++;
                if (o_overlap) n_hits++;
                if (o_overlap !== want) begin
                    $error("overlap mismatch: expected %0b actual %0b", want, o_overlap);
                    n_errors++;
                end
            end
        end
    end

    function automatic t_pair random_pair();
        t_pair x;
        int mode, spread;
        mode = $urandom_range(0, 9);
        spread = (mode < 5) ? 600 : (mode < 8) ? 4000 : 0;
        x.fb = rand_point(spread); x.ft = rand_point(spread);
        x.sb = rand_point(spread); x.st = rand_point(spread);
        if ($urandom_range(0, 15) == 0) x.ft = x.fb;
        if ($urandom_range(0, 15) == 0) x.st = x.sb;
        if ($urandom_range(0, 19) == 0) begin
            // parallel axes, built one coordinate at a time
            for (int k = 0; k < 3; k++)
                x.st[k*CB +: CB] = x.sb[k*CB +: CB] + x.ft[k*CB +: CB] - x.fb[k*CB +: CB];
        end
        x.fr = (spread == 0) ? RADIUS_W'($urandom) : RADIUS_W'($urandom_range(0, spread));
        x.sr = (spread == 0) ? RADIUS_W'($urandom) : RADIUS_W'($urandom_range(0, spread));
        if ($urandom_range(0, 19) == 0) begin x.fr = 0; x.sr = 0; end
        x.fe = ($urandom_range(0, 11) != 0);
        x.se = ($urandom_range(0, 11) != 0);
        return x;
    endfunction

    initial begin
        t_pair x;
        int n_items;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, disabled capsules, zero radii, degenerate axes.
        x = '{default: '0};
        x.fe = 1; x.se = 1; x.fr = 16'h0100;
        pending_pairs.push_back(x);                       // both axes zero, touching
        x.fe = 0; pending_pairs.push_back(x);             // first inactive
        x.fe = 1; x.se = 0; pending_pairs.push_back(x);   // second inactive
        x.se = 1; x.fr = 0; pending_pairs.push_back(x);   // zero radii, equal bottoms
        x.sb = 48'h1; pending_pairs.push_back(x);         // zero radii, bottoms differ
        x = '{fb: 48'h0, ft: 48'h0000_0000_0A00, sb: 48'h0000_0100_0500,
              st: 48'h0000_0100_0500, fr: 16'h0080, sr: 16'h0080, fe: 1, se: 1};
        pending_pairs.push_back(x);                       // second axis zero
        x.st = 48'h0000_0100_0F00; pending_pairs.push_back(x); // parallel axes
        x.ft = 48'h0; x.st = 48'h0000_0A00_0500; pending_pairs.push_back(x); // first zero
        x = '{fb: {3{16'h8000}}, ft: {3{16'h7FFF}}, sb: {3{16'h7FFF}},
              st: {3{16'h8000}}, fr: 16'hFFFF, sr: 16'hFFFF, fe: 1, se: 1};
        pending_pairs.push_back(x);                       // coordinate and radius extremes
        x.fr = 16'h0001; x.sr = 16'h0000; pending_pairs.push_back(x);
        x = '{fb: {3{16'h8000}}, ft: {3{16'h8000}}, sb: {3{16'h7FFF}},
              st: {3{16'h7FFF}}, fr: 16'hFFFF, sr: 16'hFFFF, fe: 1, se: 1};
        pending_pairs.push_back(x);                       // far apart, widest reach
        x = '{fb: 48'h0, ft: 48'h0000_0000_1000, sb: 48'h0000_0200_0800,
              st: 48'h0000_FE00_0800, fr: 16'h0100, sr: 16'h0100, fe: 1, se: 1};
        pending_pairs.push_back(x);                       // crossing segments, axes intersect
        for (int i = 0; i < 8; i++) pending_pairs.push_back(random_pair());

        // Drain completely once with the sender held back.
        wait (pending_pairs.size() == 0);
        hold_off = 1'b1;
        wait (expected_overlaps.size() == 0);
        repeat (LATENCY + 4) @(posedge i_clk);
        hold_off = 1'b0;

        n_items = 0;
        while (n_items < 1350) begin
            pending_pairs.push_back(random_pair());
            n_items++;
            if (n_items == 1150) begin
                wait (pending_pairs.size() == 0);
                calm = 1'b1;
            end
        end
        wait (pending_pairs.size() == 0);
        wait (expected_overlaps.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("Checked %0d capsule pairs (%0d overlapping), incl. inactive, zero-radius",
                 n_results, n_hits);
        $display("and degenerate-axis cases under random idling on both sides.");
        if (n_errors == 0 && expected_overlaps.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
